FILE: design/pehx_pkg.sv
// ----------------------------------------------------------------------------
// pehx_pkg
// Shared types and constants for the capture record header extractor.
// ----------------------------------------------------------------------------
package pehx_pkg;

  localparam int unsigned RecordHeaderLen = 16;
  localparam int unsigned LenFieldOffset  = 8;
  localparam int unsigned MacLen          = 6;
  localparam int unsigned EthHeaderLen    = 14;

  localparam logic [7:0] FileHeaderReset = 8'd24;

  localparam logic [1:0] PH_FILE   = 2'd0;
  localparam logic [1:0] PH_RECORD = 2'd1;
  localparam logic [1:0] PH_FRAME  = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [0:0] REG_FILE_HEADER_BYTES = 1'b0;

  typedef struct packed {
    logic       start_of_file;
    logic [7:0] data_byte;
  } in_item_t;

  // packed with packet_number in the lowest bits
  typedef struct packed {
    logic [15:0] ether_type;
    logic [47:0] source_mac;
    logic [47:0] destination_mac;
    logic [31:0] captured_length;
    logic [31:0] packet_number;
  } result_t;

endpackage

FILE: design/pcap_ethernet_header_extractor.sv
// ----------------------------------------------------------------------------
// pcap_ethernet_header_extractor
// Walks a capture byte stream and reports the Ethernet header of each record.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tdata = data_byte, tuser = start_of_file
// m_axis    out  tdata = packet_number, captured_length, dst MAC, src MAC,
//                EtherType (low bits first)
// apb       in   file_header_bytes at byte address 0
//
// One byte per clock sustained while no held result stalls the input. A byte is registered
// in the input register, and the parser updates its state and loads the result register
// when it takes the byte from there, so a result passes through both registers behind its 14th frame byte.
// Synchronous active-high reset; file_header_bytes resets to 24.
// A held result stalls the byte that would load the next result, and the bytes
// behind it wait in turn until the result is taken.
// ----------------------------------------------------------------------------
module pcap_ethernet_header_extractor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] start_of_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,   // [31:0] packet_number, [63:32] captured_length,
                                       // [111:64] destination_mac,
                                       // [159:112] source_mac, [175:160] ether_type
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pehx_pkg::*;

  logic [7:0] file_header_bytes;
  in_item_t   s_item;
  in_item_t   q_item;
  logic       q_valid;
  logic       q_take;
  result_t    result;

  assign s_item.start_of_file = s_axis_tuser;
  assign s_item.data_byte     = s_axis_tdata;

  pehx_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .file_header_bytes (file_header_bytes)
  );

  pehx_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  pehx_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .file_header_bytes (file_header_bytes),
    .in_valid          (q_valid),
    .in_item           (q_item),
    .in_take           (q_take),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_result        (result)
  );

  assign m_axis_tdata = result;

endmodule

FILE: design/pehx_cfg.sv
// ----------------------------------------------------------------------------
// pehx_cfg
// APB register file holding the global file header length.
// ----------------------------------------------------------------------------
module pehx_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  file_header_bytes
);
  import pehx_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_FILE_HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_header_bytes <= FileHeaderReset;
    end else if (wr_en) begin
      file_header_bytes <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_FILE_HEADER_BYTES) begin
      prdata = {24'd0, file_header_bytes};
    end
  end

endmodule

FILE: design/pehx_in_reg.sv
// ----------------------------------------------------------------------------
// pehx_in_reg
// Input register for the byte stream.
// ----------------------------------------------------------------------------
module pehx_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  pehx_pkg::in_item_t s_item,
  output logic              q_valid,
  output pehx_pkg::in_item_t q_item,
  input  logic              q_take
);
  import pehx_pkg::*;

  assign s_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_item <= s_item;
    end
  end

endmodule

FILE: design/pehx_parser.sv
// ----------------------------------------------------------------------------
// pehx_parser
// Capture walker: phase tracking, field capture and result register.
// ----------------------------------------------------------------------------
module pehx_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         file_header_bytes,
  input  logic               in_valid,
  input  pehx_pkg::in_item_t in_item,
  output logic               in_take,
  output logic               out_valid,
  input  logic               out_ready,
  output pehx_pkg::result_t  out_result
);
  import pehx_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [31:0] offset, offset_next;
  logic [31:0] frame_length, frame_length_next;
  logic [47:0] dst_shift, dst_shift_next;
  logic [63:0] tail_shift, tail_shift_next;
  logic [31:0] record_count, record_count_next;
  logic        emit;
  logic [1:0]  ph_a;
  logic [31:0] off_a;
  logic [31:0] off_inc;

  assign in_take = in_valid && (!emit || !out_valid || out_ready);

  always_comb begin
    ph_a              = phase;
    off_a             = offset;
    record_count_next = record_count;
    frame_length_next = frame_length;
    dst_shift_next    = dst_shift;
    tail_shift_next   = tail_shift;
    emit              = 1'b0;

    if (in_item.start_of_file) begin
      ph_a              = PH_FILE;
      off_a             = 32'd0;
      record_count_next = 32'd0;
    end
    if (ph_a == PH_FILE && off_a >= {24'd0, file_header_bytes}) begin
      ph_a  = PH_RECORD;
      off_a = 32'd0;
    end
    if ((ph_a == PH_FRAME || ph_a == PH_SKIP) && off_a >= frame_length) begin
      ph_a  = PH_RECORD;
      off_a = 32'd0;
    end

    off_inc     = off_a + 32'd1;
    phase_next  = ph_a;
    offset_next = off_inc;

    case (ph_a)
      PH_RECORD: begin
        if (off_a >= 32'(LenFieldOffset) && off_a < 32'(LenFieldOffset + 4)) begin
          frame_length_next = {in_item.data_byte, frame_length[31:8]};
        end
        if (off_inc >= 32'(RecordHeaderLen)) begin
          phase_next  = PH_FRAME;
          offset_next = 32'd0;
          if (record_count_next != 32'hFFFF_FFFF) begin
            record_count_next = record_count_next + 32'd1;
          end
        end
      end
      PH_FRAME: begin
        if (off_a < 32'(MacLen)) begin
          dst_shift_next = {dst_shift[39:0], in_item.data_byte};
        end else begin
          tail_shift_next = {tail_shift[55:0], in_item.data_byte};
        end
        if (off_inc >= 32'(EthHeaderLen)) begin
          emit       = 1'b1;
          phase_next = PH_SKIP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FILE;
      offset       <= 32'd0;
      record_count <= 32'd0;
      frame_length <= 32'd0;
    end else if (in_take) begin
      phase        <= phase_next;
      offset       <= offset_next;
      record_count <= record_count_next;
      frame_length <= frame_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dst_shift  <= dst_shift_next;
      tail_shift <= tail_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      out_result.packet_number   <= record_count_next;
      out_result.captured_length <= frame_length_next;
      out_result.destination_mac <= dst_shift_next;
      out_result.source_mac      <= tail_shift_next[63:16];
      out_result.ether_type      <= tail_shift_next[15:0];
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capture record Ethernet header extractor.
// Feeds capture byte streams (well-formed records with random content, short
// and empty frames, truncated long frames, stray bytes and restarts) under
// several file header lengths, with random idle cycles on the input side and
// random stalls on the result side. A cycle-free model of the parser predicts
// every reported header, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pehx_pkg::*;

  localparam logic [2:0] HDR_LEN_ADDR = {REG_FILE_HEADER_BYTES, 2'b00};
  localparam int         RANDOM_BYTES = 1500;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  pcap_ethernet_header_extractor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t    pending_bytes[$];
  result_t     expected_headers[$];
  int unsigned mismatches      = 0;
  int unsigned headers_checked = 0;
  int unsigned bytes_queued    = 0;
  int unsigned settings_used   = 0;

  // parser model state
  logic [7:0]  hdr_len_cfg = FileHeaderReset;
  logic [1:0]  m_phase     = PH_FILE;
  logic [31:0] m_offset    = '0;
  logic [31:0] m_frame_len = '0;
  logic [47:0] m_dst       = '0;
  logic [63:0] m_tail      = '0;
  logic [31:0] m_count     = '0;

  // stimulus shaping
  bit mark_next    = 1'b0;
  int byte_pattern = 0;
  bit in_burst     = 1'b0;
  bit out_burst    = 1'b0;
  bit in_taken     = 1'b0;
  int gap_left     = 0;
  int ready_wait   = 0;

  function automatic int draw_wait(ref bit burst);
    int n;
    n = burst ? 0 : $urandom_range(0, 4);
    if ($urandom_range(0, 40) == 0) burst = !burst;
    return n;
  endfunction

  task automatic track_capture_byte(input logic [7:0] b, input logic sof);
    result_t r;
    if (sof) begin
      m_phase  = PH_FILE;
      m_offset = '0;
      m_count  = '0;
    end
    if (m_phase == PH_FILE && m_offset >= {24'b0, hdr_len_cfg}) begin
      m_phase  = PH_RECORD;
      m_offset = '0;
    end
    if ((m_phase == PH_FRAME || m_phase == PH_SKIP) && m_offset >= m_frame_len) begin
      m_phase  = PH_RECORD;
      m_offset = '0;
    end
    case (m_phase)
      PH_RECORD: begin
        if (m_offset >= LenFieldOffset && m_offset < LenFieldOffset + 4)
          m_frame_len = {b, m_frame_len[31:8]};
        m_offset++;
        if (m_offset >= RecordHeaderLen) begin
          m_phase  = PH_FRAME;
          m_offset = '0;
          if (m_count != '1) m_count++;
        end
      end
      PH_FRAME: begin
        if (m_offset < MacLen) m_dst = {m_dst[39:0], b};
        else m_tail = {m_tail[55:0], b};
        m_offset++;
        if (m_offset >= EthHeaderLen) begin
          r.packet_number   = m_count;
          r.captured_length = m_frame_len;
          r.destination_mac = m_dst;
          r.source_mac      = m_tail[63:16];
          r.ether_type      = m_tail[15:0];
          expected_headers.push_back(r);
          m_phase = PH_SKIP;
        end
      end
      default: m_offset++;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1'b1;
      track_capture_byte(s_axis_tdata, s_axis_tuser);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_t got;
      result_t exp;
      got = result_t'(m_axis_tdata);
      ready_wait = draw_wait(out_burst);
      if (expected_headers.size() == 0) begin
        $error("unexpected header result: packet_number %0d", got.packet_number);
        mismatches++;
      end else begin
        exp = expected_headers.pop_front();
        headers_checked++;
        if (got.packet_number !== exp.packet_number) begin
          $error("packet_number: expected %0d, got %0d", exp.packet_number,
                 got.packet_number);
          mismatches++;
        end
        if (got.captured_length !== exp.captured_length) begin
          $error("captured_length: expected %0h, got %0h", exp.captured_length,
                 got.captured_length);
          mismatches++;
        end
        if (got.destination_mac !== exp.destination_mac) begin
          $error("destination_mac: expected %012h, got %012h", exp.destination_mac,
                 got.destination_mac);
          mismatches++;
        end
        if (got.source_mac !== exp.source_mac) begin
          $error("source_mac: expected %012h, got %012h", exp.source_mac,
                 got.source_mac);
          mismatches++;
        end
        if (got.ether_type !== exp.ether_type) begin
          $error("ether_type: expected %04h, got %04h", exp.ether_type, got.ether_type);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold until taken
    end else begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() != 0) begin
        in_item_t it;
        it = pending_bytes.pop_front();
        s_axis_tdata  <= it.data_byte;
        s_axis_tuser  <= it.start_of_file;
        s_axis_tvalid <= 1'b1;
        gap_left = draw_wait(in_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      m_axis_tready <= 1'b0;
      ready_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] next_byte();
    case (byte_pattern)
      1:       return 8'h00;
      2:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte     = b;
    it.start_of_file = mark_next;
    mark_next = 1'b0;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_capture_start(input int header_bytes);
    mark_next = 1'b1;
    for (int i = 0; i < header_bytes; i++) push_byte(next_byte());
  endtask

  task automatic push_record(input logic [31:0] cap_len, input int frame_bytes);
    for (int i = 0; i < 8; i++) push_byte(next_byte());
    for (int i = 0; i < 4; i++) push_byte(cap_len[8*i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(next_byte());
    for (int i = 0; i < frame_bytes; i++) push_byte(next_byte());
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_headers.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_header_len(input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HDR_LEN_ADDR;
    pwdata  <= {24'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    hdr_len_cfg = value;
    settings_used++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, value}) begin
      $error("file_header_bytes readback: expected %0d, got %0d", value, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_random_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_queued + budget;
    byte_pattern = 0;
    push_capture_start(hdr_len_cfg);
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(14, 64);
        push_record(pick, pick);
      end else if (pick < 85) begin
        pick = $urandom_range(0, 13);
        push_record(pick, pick);
      end else if (pick < 91) begin
        // long frame cut short, then restart the capture
        push_record($urandom_range(65, 32'hFFFF_FFFF), 14 + $urandom_range(0, 10));
        push_capture_start(hdr_len_cfg);
      end else if (pick < 96) begin
        pick = $urandom_range(1, 8);
        for (int i = 0; i < pick; i++) begin
          mark_next = ($urandom_range(0, 7) == 0);
          push_byte(8'($urandom));
        end
        push_capture_start(hdr_len_cfg);
      end else begin
        push_capture_start(hdr_len_cfg);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no start mark after reset, default header length
    byte_pattern = 2;
    for (int i = 0; i < 24; i++) push_byte(next_byte());
    push_record(32'd14, 14);
    byte_pattern = 1;
    push_record(32'd20, 20);
    wait_quiet();

    // empty global header, empty, short and huge frames
    set_header_len(8'd0);
    byte_pattern = 0;
    push_capture_start(0);
    push_record(32'd0, 0);
    push_record(32'd5, 5);
    push_record(32'd14, 14);
    push_record(32'hFFFF_FFFF, 16);
    push_capture_start(0);
    push_record(32'd15, 15);
    wait_quiet();

    // change the header length while the global header is being skipped
    set_header_len(8'd30);
    push_capture_start(10);
    wait_quiet();
    set_header_len(8'd4);
    push_record(32'd15, 15);
    push_record(32'd13, 13);
    wait_quiet();

    set_header_len(8'd255);
    push_random_traffic(RANDOM_BYTES / 5);
    wait_quiet();
    set_header_len(FileHeaderReset);
    push_random_traffic(RANDOM_BYTES / 5);
    wait_quiet();
    set_header_len(8'($urandom_range(2, 254)));
    push_random_traffic(RANDOM_BYTES / 5);
    wait_quiet();
    set_header_len(8'd1);
    push_random_traffic(RANDOM_BYTES / 5);
    wait_quiet();
    set_header_len(8'd0);
    push_random_traffic(RANDOM_BYTES / 5);
    wait_quiet();

    $display("Streamed %0d capture bytes under %0d header length settings;",
             bytes_queued, settings_used);
    $display("%0d Ethernet headers compared against the parser model.", headers_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
